>>> rtl/svd_pkg.sv
// ----------------------------------------------------------------------------
// svd_pkg
// Types and constants shared by the SVPWM duty calculator modules.
// ----------------------------------------------------------------------------
package svd_pkg;

  // Q16 coefficients of the sector projections.
  localparam logic [16:0] SQRT3_Q16     = 17'd113512;
  localparam logic [16:0] HALF3_Q16     = 17'd98304;
  localparam logic [16:0] HALFSQRT3_Q16 = 17'd56756;

  localparam logic [15:0] PERIOD_RESET = 16'd16800;
  localparam logic [15:0] BUS_RESET    = 16'd6144;

  // Significant bits of the period register.
  localparam int unsigned PERIOD_BITS = 16;

  localparam logic [14:0] CMP_MAX = 15'd32767;

  // Sector codes from the three sign tests.
  localparam logic [2:0] SECTOR_ZERO = 3'd0;
  localparam logic [2:0] SECTOR_1    = 3'd1;
  localparam logic [2:0] SECTOR_2    = 3'd2;
  localparam logic [2:0] SECTOR_3    = 3'd3;
  localparam logic [2:0] SECTOR_4    = 3'd4;
  localparam logic [2:0] SECTOR_5    = 3'd5;
  localparam logic [2:0] SECTOR_6    = 3'd6;
  localparam logic [2:0] SECTOR_BAD  = 3'd7;

  // Register byte addresses.
  localparam logic [2:0] ADDR_PERIOD = 3'd0;
  localparam logic [2:0] ADDR_BUS    = 3'd4;

  // Divider geometry: 43 quotient bits, 45-bit remainder and divisor.
  localparam int unsigned QW = 43;
  localparam int unsigned RW = 45;

  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
  } in_word_t;

  typedef struct packed {
    logic [14:0] compare_u;
    logic [14:0] compare_v;
    logic [14:0] compare_w;
    logic [2:0]  sector_code;
    logic        overmodulated;
  } out_word_t;

  // One classified job: signed numerators of the two active times, times period.
  typedef struct packed {
    logic [2:0]         code;
    logic signed [50:0] mx;
    logic signed [50:0] my;
  } job_t;

  typedef struct packed {
    logic          start;
    logic [RW-1:0] rem;
    logic [QW-1:0] low;
    logic [5:0]    nbits;
    logic [RW-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/svd_fifo.sv
// ----------------------------------------------------------------------------
// svd_fifo
// Two-entry job queue between the classifier and the time sequencer.
// ----------------------------------------------------------------------------
module svd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  svd_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output svd_pkg::job_t rdata_o
);
  import svd_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full job queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty job queue");

endmodule

>>> rtl/svd_front.sv
// ----------------------------------------------------------------------------
// svd_front
// Sector classification and projection numerators scaled by the period.
// ----------------------------------------------------------------------------
module svd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  svd_pkg::in_word_t in_word_i,
  input  logic [15:0]       period_i,
  output logic              push_o,
  input  logic              full_i,
  output svd_pkg::job_t     job_o
);
  import svd_pkg::*;

  logic               s1_v_q;
  logic [2:0]         code_q, code_d;
  logic signed [34:0] ntx_q, nty_q, ntx_d, nty_d;

  logic signed [34:0] s, w, nx, ny, nz, a98, b56;
  logic signed [16:0] p_s;

  always_comb begin
    s   = 35'(in_word_i.v_alpha * $signed({1'b0, SQRT3_Q16}));
    w   = 35'({{19{in_word_i.v_beta[15]}}, in_word_i.v_beta} <<< 16);
    nx  = 35'(in_word_i.v_beta * $signed({1'b0, SQRT3_Q16}));
    a98 = 35'(in_word_i.v_alpha * $signed({1'b0, HALF3_Q16}));
    b56 = 35'(in_word_i.v_beta * $signed({1'b0, HALFSQRT3_Q16}));
    ny  = a98 + b56;
    nz  = b56 - a98;
    code_d = {(-s - w) > 0, (s - w) > 0, in_word_i.v_beta > 0};
    unique case (code_d)
      SECTOR_1: begin ntx_d = nz;  nty_d = ny;  end
      SECTOR_2: begin ntx_d = ny;  nty_d = -nx; end
      SECTOR_3: begin ntx_d = -nz; nty_d = nx;  end
      SECTOR_4: begin ntx_d = -nx; nty_d = nz;  end
      SECTOR_5: begin ntx_d = nx;  nty_d = -ny; end
      default:  begin ntx_d = -ny; nty_d = -nz; end
    endcase
  end

  assign push_o     = s1_v_q && !full_i;
  assign in_ready_o = !s1_v_q || !full_i;
  assign p_s        = $signed({1'b0, period_i});

  assign job_o.code = code_q;
  assign job_o.mx   = 51'(ntx_q * p_s);
  assign job_o.my   = 51'(nty_q * p_s);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      code_q <= code_d;
      ntx_q  <= ntx_d;
      nty_q  <= nty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

endmodule

>>> rtl/svd_div.sv
// ----------------------------------------------------------------------------
// svd_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  svd_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [svd_pkg::QW-1:0]      quot_o
);
  import svd_pkg::*;

  logic [RW-1:0] rem_q, dvs_q;
  logic [QW-1:0] low_q, quot_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;
  logic [RW:0]   trial;
  logic          ge;

  assign trial  = {rem_q, low_q[QW-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem;
      low_q  <= req_i.low;
      dvs_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? RW'(trial - {1'b0, dvs_q}) : RW'(trial);
      low_q  <= {low_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/svd_back.sv
// ----------------------------------------------------------------------------
// svd_back
// Time sequencer: active times, overmodulation scaling, compare values.
// ----------------------------------------------------------------------------
module svd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  svd_pkg::job_t      job_i,
  output logic               pop_o,
  input  logic [15:0]        period_i,
  input  logic [15:0]        bus_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output svd_pkg::out_word_t out_word_o
);
  import svd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIVX = 4'd1;
  localparam logic [3:0] ST_DIVY = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_DIVK = 4'd4;
  localparam logic [3:0] ST_MX0  = 4'd5;
  localparam logic [3:0] ST_MX1  = 4'd6;
  localparam logic [3:0] ST_MY0  = 4'd7;
  localparam logic [3:0] ST_MY1  = 4'd8;
  localparam logic [3:0] ST_EDGE = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  localparam logic [QW-1:0] TLIM = QW'(1) << (QW - 1);

  logic [3:0]         state_q, state_d;
  logic [2:0]         code_q;
  logic signed [50:0] my_q;
  logic               negx_q, negy_q, satx_q, saty_q, ov_q;
  logic signed [43:0] tx_q, ty_q, tx_d, ty_d;
  logic [19:0]        k_q;
  logic [62:0]        acc_q;
  logic signed [47:0] ta_q, tb_q, tc_q;
  logic               out_valid_q;
  out_word_t          out_q;

  div_req_t           req;
  logic               div_done;
  logic [QW-1:0]      quot;

  logic signed [50:0] src;
  logic [48:0]        mag;
  logic               src_sat;
  logic [15:0]        u;
  logic [31:0]        pq;
  logic signed [44:0] sum;
  logic [QW-1:0]      qsat, mxm, mym;
  logic [40:0]        hi_prod;
  logic [62:0]        acc_fin;
  logic [QW-1:0]      scaled;
  logic signed [47:0] ta, tb, tc;
  logic signed [47:0] cu, cv, cw;

  svd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (div_done),
    .quot_o (quot)
  );

  function automatic logic [14:0] to_ticks(input logic signed [47:0] t);
    if (t <= 0) return '0;
    if (t[46:33] != '0) return CMP_MAX;
    return t[32:18];
  endfunction

  function automatic logic signed [43:0] apply_sign(input logic neg, input logic [QW-1:0] m);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  assign u       = (bus_i == '0) ? 16'd1 : bus_i;
  assign pq      = {period_i, 16'd0};
  assign src     = (state_q == ST_IDLE) ? job_i.mx : my_q;
  assign mag     = 49'(src[50] ? -src : src);
  // A quotient of 2^43 or more saturates anyway; the divider keeps only the low 43 quotient bits.
  assign src_sat = {10'd0, mag[48:43]} >= u;
  assign qsat    = (quot > TLIM) ? TLIM : quot;
  assign sum     = 45'(tx_q) + 45'(ty_q);
  assign mxm     = QW'(tx_q[43] ? -tx_q : tx_q);
  assign mym     = QW'(ty_q[43] ? -ty_q : ty_q);
  assign pop_o   = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    req.start   = 1'b0;
    req.rem     = RW'(mag[48:43]);
    req.low     = mag[42:0];
    req.nbits   = 6'(QW);
    req.divisor = RW'(u);
    if (pop_o || (state_q == ST_DIVX && div_done)) begin
      req.start = 1'b1;
    end else if (state_q == ST_SUM && sum > $signed({13'd0, pq})) begin
      req.start   = 1'b1;
      req.rem     = RW'(pq);
      req.low     = '0;
      req.nbits   = 6'd20;
      req.divisor = sum;
    end
  end

  // The edge times are written out from pq, tx and ty so that the three
  // sums are independent of each other.
  always_comb begin
    hi_prod = 41'((state_q == ST_MX1 ? mxm[42:22] : mym[42:22]) * k_q);
    acc_fin = acc_q + {hi_prod, 22'd0};
    scaled  = acc_fin[62:20];
    ta = 48'($signed({16'd0, pq})) - 48'(tx_q) - 48'(ty_q);
    tb = 48'($signed({16'd0, pq})) + 48'(tx_q) - 48'(ty_q);
    tc = 48'($signed({16'd0, pq})) + 48'(tx_q) + 48'(ty_q);
    unique case (code_q)
      SECTOR_1: begin cu = tb_q; cv = ta_q; cw = tc_q; end
      SECTOR_2: begin cu = ta_q; cv = tc_q; cw = tb_q; end
      SECTOR_3: begin cu = ta_q; cv = tb_q; cw = tc_q; end
      SECTOR_4: begin cu = tc_q; cv = tb_q; cw = ta_q; end
      SECTOR_5: begin cu = tc_q; cv = ta_q; cw = tb_q; end
      default:  begin cu = tb_q; cv = tc_q; cw = ta_q; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    unique case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_DIVX;
      ST_DIVX: if (div_done) begin
        tx_d    = apply_sign(negx_q, satx_q ? TLIM : qsat);
        state_d = ST_DIVY;
      end
      ST_DIVY: if (div_done) begin
        ty_d    = apply_sign(negy_q, saty_q ? TLIM : qsat);
        state_d = ST_SUM;
      end
      ST_SUM:  state_d = req.start ? ST_DIVK : ST_EDGE;
      ST_DIVK: if (div_done) state_d = ST_MX0;
      ST_MX0:  state_d = ST_MX1;
      ST_MX1: begin
        tx_d    = apply_sign(tx_q[43], scaled);
        state_d = ST_MY0;
      end
      ST_MY0:  state_d = ST_MY1;
      ST_MY1: begin
        ty_d    = apply_sign(ty_q[43], scaled);
        state_d = ST_EDGE;
      end
      ST_EDGE: state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tx_q <= tx_d;
    ty_q <= ty_d;
    if (pop_o) begin
      code_q <= job_i.code;
      my_q   <= job_i.my;
      negx_q <= job_i.mx[50];
      satx_q <= src_sat;
      ov_q   <= 1'b0;
    end
    if (state_q == ST_DIVX) begin
      negy_q <= my_q[50];
      saty_q <= src_sat;
    end
    if (state_q == ST_SUM) ov_q <= req.start;
    if (state_q == ST_DIVK) k_q <= quot[19:0];
    if (state_q == ST_MX0) acc_q <= 63'(mxm[21:0] * k_q);
    if (state_q == ST_MY0) acc_q <= 63'(mym[21:0] * k_q);
    if (state_q == ST_EDGE) begin
      ta_q <= ta;
      tb_q <= tb;
      tc_q <= tc;
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.compare_u     <= to_ticks(cu);
      out_q.compare_v     <= to_ticks(cv);
      out_q.compare_w     <= to_ticks(cw);
      out_q.sector_code   <= code_q;
      out_q.overmodulated <= ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVX || state_q == ST_DIVY || state_q == ST_DIVK))
    else $error("divider finished outside a divide step");
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.sector_code == SECTOR_ZERO |->
      out_q.compare_u == out_q.compare_v && out_q.compare_v == out_q.compare_w)
    else $error("zero vector gave unequal compare values");
  a_no_bad_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.sector_code != SECTOR_BAD)
    else $error("impossible sector code delivered");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_DIVX)
    else $error("job taken without starting the first divide");

endmodule

>>> rtl/svpwm_duty_calc.sv
// ----------------------------------------------------------------------------
// svpwm_duty_calc
// Seven-segment space vector PWM duty calculator.
//
// One input word carries an alpha/beta voltage reference; each accepted word
// gives exactly one output word with the three phase compare values, the raw
// sector code and the overmodulation flag. Both channels are valid/ready.
// The front stage classifies the sector and forms the two scaled numerators
// and queues them (two entries); the back sequencer then works
// through them with one shared radix-2 divider, one bit per cycle.
// The back sequencer takes a new word only once it has finished the last;
// overmodulation scaling adds one extra 20-bit divide and two split
// multiplies to a word. The front keeps accepting while the back works,
// until the queue is full.
// The output register holds a finished word while out_ready_i is low; the
// back sequencer waits on it and the front fills the queue, then in_ready_o
// drops. Reset empties the pipeline and loads pwm_period = 16800 and
// bus_voltage = 6144. Registers sit on an APB port at 0x0 and 0x4.
// ----------------------------------------------------------------------------
module svpwm_duty_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  svd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output svd_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import svd_pkg::*;

  localparam logic [15:0] PMASK =
    (PERIOD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << PERIOD_BITS) - 32'd1);

  logic [15:0] period_q, bus_q, period_eff;
  logic        wr_en;
  logic        push, full, pop, empty;
  job_t        wjob, rjob;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign period_eff = period_q & PMASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      bus_q    <= BUS_RESET;
    end else if (wr_en) begin
      if (paddr == ADDR_PERIOD) period_q <= pwdata[15:0];
      if (paddr == ADDR_BUS)    bus_q    <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_PERIOD: prdata = {16'd0, period_q};
      ADDR_BUS:    prdata = {16'd0, bus_q};
      default:     prdata = '0;
    endcase
  end

  svd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .period_i   (period_eff),
    .push_o     (push),
    .full_i     (full),
    .job_o      (wjob)
  );

  svd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rjob)
  );

  svd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (rjob),
    .pop_o       (pop),
    .period_i    (period_eff),
    .bus_i       (bus_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
